### hdl/ikarm_pkg.sv
// ----------------------------------------------------------------------------
// ikarm_pkg
// Shared widths, register indexes and the arctangent table for the
// two-link arm inverse kinematics block.
// ----------------------------------------------------------------------------
package ikarm_pkg;

    localparam int COORD_W    = 24;
    localparam int LEN_W      = 23;
    localparam int ANGLE_W    = 20;
    localparam int TABLE_LEN  = 28;
    localparam int NORM_LIM   = 40;   // operands are doubled up to 2^40
    localparam int NORM_STEPS = 7;    // shifts of 32,16,8,4,2,1 and a final 1

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [LEN_W-1:0]   len_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    localparam logic CFG_UPPER = 1'b0;
    localparam logic CFG_LOWER = 1'b1;

    localparam len_t LEN_RESET = 23'd1966;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // atan(2^-i) in Q.30
    localparam logic [31:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8
    };

    // Q.30 angle rounded half up to f fractional bits
    function automatic logic [32:0] qang(input logic [31:0] a, input int f);
        logic [32:0] r;
        r = ({1'b0, a} + (33'd1 << (29 - f))) >> (30 - f);
        return r;
    endfunction

endpackage

### hdl/ikarm_cosine.sv
// ----------------------------------------------------------------------------
// ikarm_cosine
// Squares, numerator and denominator of the elbow cosine, then a
// restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module ikarm_cosine #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              en,
    input  ikarm_pkg::coord_t x,
    input  ikarm_pkg::coord_t y,
    input  ikarm_pkg::len_t   l1,
    input  ikarm_pkg::len_t   l2,
    output logic [FRAC_BITS:0] q,
    output logic              neg,
    output logic              ok
);
    import ikarm_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int RW = 49;

    logic signed [47:0] xsq, ysq;
    logic [46:0] xx_reg, yy_reg;
    logic [45:0] l11_reg, l22_reg, l12_reg;

    logic [RW-1:0] a_reg, b_reg, den2_reg;
    logic [RW-1:0] anum_reg, den3_reg;
    logic          neg3_reg;

    logic [RW-1:0] rem_reg  [0:F];
    logic [RW-1:0] den_reg  [0:F];
    logic [F-1:0]  q_reg    [0:F];
    logic          sat_reg  [0:F];
    logic          ok_reg   [0:F];
    logic          neg_reg  [0:F];

    logic [RW-1:0] rem_next [1:F];
    logic [F-1:0]  q_next   [1:F];

    assign xsq = x * x;
    assign ysq = y * y;

    always_comb
    begin
        logic [RW-1:0] t;
        for (int k = 0; k < F; k++)
        begin
            t = {rem_reg[k][RW-2:0], 1'b0};
            if (t >= den_reg[k])
            begin
                rem_next[k+1] = t - den_reg[k];
                q_next[k+1]   = {q_reg[k][F-2:0], 1'b1};
            end
            else
            begin
                rem_next[k+1] = t;
                q_next[k+1]   = {q_reg[k][F-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg  <= xsq[46:0];
            yy_reg  <= ysq[46:0];
            l11_reg <= l1 * l1;
            l22_reg <= l2 * l2;
            l12_reg <= l1 * l2;

            a_reg    <= RW'(xx_reg) + RW'(yy_reg);
            b_reg    <= RW'(l11_reg) + RW'(l22_reg);
            den2_reg <= RW'({l12_reg, 1'b0});

            neg3_reg <= a_reg < b_reg;
            anum_reg <= (a_reg < b_reg) ? (b_reg - a_reg) : (a_reg - b_reg);
            den3_reg <= den2_reg;

            // zero length gives a zero denominator: D taken as +1
            rem_reg[0] <= anum_reg;
            den_reg[0] <= den3_reg;
            q_reg[0]   <= '0;
            sat_reg[0] <= (den3_reg == '0) || (anum_reg >= den3_reg);
            ok_reg[0]  <= (den3_reg != '0) && (anum_reg <= den3_reg);
            neg_reg[0] <= neg3_reg && (den3_reg != '0);

            for (int k = 1; k <= F; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                den_reg[k] <= den_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                ok_reg[k]  <= ok_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign q   = sat_reg[F] ? (F+1)'(1) << F : {1'b0, q_reg[F]};
    assign neg = neg_reg[F];
    assign ok  = ok_reg[F];

endmodule

### hdl/ikarm_sine.sv
// ----------------------------------------------------------------------------
// ikarm_sine
// Signed cosine, sine by a digit-by-digit square root (one result bit per
// stage), and the operands of the second arctangent.
// ----------------------------------------------------------------------------
module ikarm_sine #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [FRAC_BITS:0]         q,
    input  logic                       neg,
    input  ikarm_pkg::len_t            l1,
    input  ikarm_pkg::len_t            l2,
    output logic signed [FRAC_BITS+1:0]  d,
    output logic [FRAC_BITS:0]         s,
    output logic signed [FRAC_BITS+25:0] by,
    output logic signed [FRAC_BITS+25:0] bx
);
    import ikarm_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int VW = 2*F + 2;
    localparam int BW = F + 26;

    logic signed [F+1:0] d1_reg;
    logic [VW-1:0]       qq_reg;

    logic [VW-1:0]       v_reg [0:F+1];
    logic [VW-1:0]       r_reg [0:F+1];
    logic signed [F+1:0] ds_reg [0:F+1];
    logic [VW-1:0]       v_next [1:F+1];
    logic [VW-1:0]       r_next [1:F+1];

    logic signed [BW-1:0] by_m_reg, p_m_reg;
    logic signed [F+1:0]  d_m_reg;
    logic [F:0]           s_m_reg;

    logic signed [BW-1:0] by_reg, bx_reg;
    logic signed [F+1:0]  d_reg;
    logic [F:0]           s_reg;

    logic signed [BW-1:0] by_prod, p_prod;

    always_comb
    begin
        logic [VW-1:0] bitv;
        for (int k = 0; k <= F; k++)
        begin
            bitv = VW'(1) << (2*(F-k));
            if (v_reg[k] >= r_reg[k] + bitv)
            begin
                v_next[k+1] = v_reg[k] - (r_reg[k] + bitv);
                r_next[k+1] = (r_reg[k] >> 1) + bitv;
            end
            else
            begin
                v_next[k+1] = v_reg[k];
                r_next[k+1] = r_reg[k] >> 1;
            end
        end
    end

    assign by_prod = $signed({1'b0, l2}) * $signed({1'b0, r_reg[F+1][F:0]});
    assign p_prod  = $signed({1'b0, l2}) * ds_reg[F+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
            qq_reg <= q * q;

            v_reg[0]  <= (VW'(1) << (2*F)) - qq_reg;
            r_reg[0]  <= '0;
            ds_reg[0] <= d1_reg;

            for (int k = 1; k <= F+1; k++)
            begin
                v_reg[k]  <= v_next[k];
                r_reg[k]  <= r_next[k];
                ds_reg[k] <= ds_reg[k-1];
            end

            by_m_reg <= by_prod;
            p_m_reg  <= p_prod;
            d_m_reg  <= ds_reg[F+1];
            s_m_reg  <= r_reg[F+1][F:0];

            by_reg <= by_m_reg;
            bx_reg <= $signed(BW'({l1, {F{1'b0}}})) + p_m_reg;
            d_reg  <= d_m_reg;
            s_reg  <= s_m_reg;
        end
    end

    assign d  = d_reg;
    assign s  = s_reg;
    assign by = by_reg;
    assign bx = bx_reg;

endmodule

### hdl/ikarm_cordic.sv
// ----------------------------------------------------------------------------
// ikarm_cordic
// Pipelined atan2: axis and quadrant handling, normalisation towards 2^40
// in seven shift steps, then one vectoring iteration per stage.
// ----------------------------------------------------------------------------
module ikarm_cordic #(
    parameter int IW        = 24,
    parameter int FRAC_BITS = 16,
    parameter int NSTAGES   = 18
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [IW-1:0]       y,
    input  logic signed [IW-1:0]       x,
    output logic signed [FRAC_BITS+3:0] z
);
    import ikarm_pkg::*;

    localparam int MAGB = (IW > NORM_LIM + 1) ? IW : NORM_LIM + 1;
    localparam int CW   = MAGB + 3;
    localparam int ZW   = FRAC_BITS + 4;
    localparam int LAST = NORM_STEPS + NSTAGES;

    localparam logic signed [ZW-1:0] PI_Z = ZW'(qang(PI_Q30, FRAC_BITS));
    localparam logic signed [ZW-1:0] HP_Z = ZW'(qang(HALF_PI_Q30, FRAC_BITS));

    logic signed [CW-1:0] x_reg [0:LAST];
    logic signed [CW-1:0] y_reg [0:LAST];
    logic signed [ZW-1:0] z_reg [0:LAST];
    logic                 fix_reg [0:LAST];

    logic signed [CW-1:0] x_next [0:LAST];
    logic signed [CW-1:0] y_next [0:LAST];
    logic signed [ZW-1:0] z_next [0:LAST];
    logic                 fix_next [0:LAST];

    logic signed [CW-1:0] xe, ye;

    assign xe = CW'(x);
    assign ye = CW'(y);

    always_comb
    begin
        int sh;
        logic signed [CW-1:0] lim, dx, dy;
        logic signed [ZW-1:0] at;
        logic fits;
        int k;

        x_next[0]   = xe;
        y_next[0]   = ye;
        z_next[0]   = '0;
        fix_next[0] = 1'b0;
        if (ye == 0)
        begin
            fix_next[0] = 1'b1;
            z_next[0]   = (xe < 0) ? PI_Z : '0;
        end
        else if (xe == 0)
        begin
            fix_next[0] = 1'b1;
            z_next[0]   = (ye > 0) ? HP_Z : -HP_Z;
        end
        else if (xe < 0)
        begin
            // rotate into the right half plane
            if (ye > 0)
            begin
                x_next[0] = ye;
                y_next[0] = -xe;
                z_next[0] = HP_Z;
            end
            else
            begin
                x_next[0] = -ye;
                y_next[0] = xe;
                z_next[0] = -HP_Z;
            end
        end

        for (int j = 0; j < NORM_STEPS; j++)
        begin
            sh   = (j < NORM_STEPS - 1) ? (32 >> j) : 1;
            // binary steps stop below 2^40; the last one doubles past it
            lim  = CW'(1) << ((j < NORM_STEPS - 1) ? (NORM_LIM - sh) : NORM_LIM);
            fits = (x_reg[j] < lim) && (x_reg[j] > -lim)
                && (y_reg[j] < lim) && (y_reg[j] > -lim);
            x_next[j+1]   = fits ? (x_reg[j] <<< sh) : x_reg[j];
            y_next[j+1]   = fits ? (y_reg[j] <<< sh) : y_reg[j];
            z_next[j+1]   = z_reg[j];
            fix_next[j+1] = fix_reg[j];
        end

        for (int i = 0; i < NSTAGES; i++)
        begin
            k  = NORM_STEPS + i;
            dx = x_reg[k] >>> i;
            dy = y_reg[k] >>> i;
            at = ZW'(qang(ATAN_Q30[i], FRAC_BITS));
            fix_next[k+1] = fix_reg[k];
            if (fix_reg[k])
            begin
                x_next[k+1] = x_reg[k];
                y_next[k+1] = y_reg[k];
                z_next[k+1] = z_reg[k];
            end
            else if (y_reg[k] > 0)
            begin
                x_next[k+1] = x_reg[k] + dy;
                y_next[k+1] = y_reg[k] - dx;
                z_next[k+1] = z_reg[k] + at;
            end
            else
            begin
                x_next[k+1] = x_reg[k] - dy;
                y_next[k+1] = y_reg[k] + dx;
                z_next[k+1] = z_reg[k] - at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                z_reg[k]   <= z_next[k];
                fix_reg[k] <= fix_next[k];
            end
        end
    end

    assign z = z_reg[LAST];

endmodule

### hdl/two_link_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics
// Elbow-down inverse kinematics of a planar two-link arm in fixed point.
//
//   channel  signals                              width  role
//   target   target_valid/target_stall, x, y      24+24  input beat
//   angle    angle_valid/angle_stall, shoulder,   20+20+1 result beat
//            elbow, reachable
//   config   cfg_write, cfg_index, cfg_data       1+1+23 link lengths
//
// One beat in per cycle while target_stall is low, one result per beat:
// the divider and square root take one bit per stage and the three
// atan2 units one iteration per stage each.
// Reset clears the valid pipeline and loads both lengths with 1966.
// A held result freezes the whole pipeline; target_stall is raised then.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_kinematics #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              target_valid,
    output logic              target_stall,
    input  ikarm_pkg::coord_t target_x,
    input  ikarm_pkg::coord_t target_y,
    output logic              angle_valid,
    input  logic              angle_stall,
    output ikarm_pkg::angle_t shoulder_angle,
    output ikarm_pkg::angle_t elbow_angle,
    output logic              reachable,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  ikarm_pkg::len_t   cfg_data
);
    import ikarm_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int NS   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int ZW   = F + 4;
    localparam int BW   = F + 26;
    localparam int LC   = F + 4;
    localparam int LS   = F + 5;
    localparam int LCOR = NS + NORM_STEPS + 1;
    localparam int LXY  = LC + LS;
    localparam int LOK  = LS + LCOR;
    localparam int LT   = LC + LS + LCOR;

    len_t upper_reg, lower_reg;

    logic            en;
    logic [LT-1:0]   vld_reg;
    logic            out_vld_reg;
    angle_t          shoulder_reg, elbow_reg;
    logic            reach_reg;

    coord_t          xd_reg [0:LXY-1];
    coord_t          yd_reg [0:LXY-1];
    logic [LOK-1:0]  okd_reg;

    logic [F:0]          q;
    logic                neg, ok;
    logic signed [F+1:0] d;
    logic [F:0]          s;
    logic signed [BW-1:0] by, bx;
    logic signed [ZW-1:0] z_target, z_link, z_elbow;
    logic signed [ZW:0]   diff;

    assign en           = !out_vld_reg || !angle_stall;
    assign target_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= LEN_RESET;
            lower_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_UPPER: upper_reg <= cfg_data;
                CFG_LOWER: lower_reg <= cfg_data;
                default:   upper_reg <= upper_reg;
            endcase
        end
    end

    ikarm_cosine #(.FRAC_BITS(F)) u_cosine (
        .clk (clk),
        .en  (en),
        .x   (target_x),
        .y   (target_y),
        .l1  (upper_reg),
        .l2  (lower_reg),
        .q   (q),
        .neg (neg),
        .ok  (ok)
    );

    ikarm_sine #(.FRAC_BITS(F)) u_sine (
        .clk (clk),
        .en  (en),
        .q   (q),
        .neg (neg),
        .l1  (upper_reg),
        .l2  (lower_reg),
        .d   (d),
        .s   (s),
        .by  (by),
        .bx  (bx)
    );

    ikarm_cordic #(.IW(COORD_W), .FRAC_BITS(F), .NSTAGES(NS)) u_cordic_target (
        .clk (clk),
        .en  (en),
        .y   (yd_reg[LXY-1]),
        .x   (xd_reg[LXY-1]),
        .z   (z_target)
    );

    ikarm_cordic #(.IW(F+2), .FRAC_BITS(F), .NSTAGES(NS)) u_cordic_elbow (
        .clk (clk),
        .en  (en),
        .y   ($signed({1'b0, s})),
        .x   (d),
        .z   (z_elbow)
    );

    ikarm_cordic #(.IW(BW), .FRAC_BITS(F), .NSTAGES(NS)) u_cordic_link (
        .clk (clk),
        .en  (en),
        .y   (by),
        .x   (bx),
        .z   (z_link)
    );

    assign diff = (ZW+1)'(z_target) - (ZW+1)'(z_link);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LT-2:0], target_valid};
            out_vld_reg <= vld_reg[LT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= target_x;
            yd_reg[0] <= target_y;
            for (int k = 1; k < LXY; k++)
            begin
                xd_reg[k] <= xd_reg[k-1];
                yd_reg[k] <= yd_reg[k-1];
            end
            okd_reg <= {okd_reg[LOK-2:0], ok};

            // angles wrap to the output width
            shoulder_reg <= ANGLE_W'(diff);
            elbow_reg    <= ANGLE_W'(z_elbow);
            reach_reg    <= okd_reg[LOK-1];
        end
    end

    assign angle_valid    = out_vld_reg;
    assign shoulder_angle = shoulder_reg;
    assign elbow_angle    = elbow_reg;
    assign reachable      = reach_reg;

endmodule
